/* hw/rtl/pixel_histogram_statistics_assert.svh */
// ----------------------------------------------------------------------------
// Pixel histogram statistics assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_HISTOGRAM_STATISTICS_ASSERT_SVH
`define PIXEL_HISTOGRAM_STATISTICS_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PHS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PHS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/phs_pkg.sv */
// ----------------------------------------------------------------------------
// Pixel histogram statistics package
// Item types, opcodes and default sizes shared by the histogram modules.
// ----------------------------------------------------------------------------
`default_nettype none

package phs_pkg;

    localparam int BIN_COUNT_DEF  = 256;
    localparam int COUNT_BITS_DEF = 24;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REPORT = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } phs_op_t;

    localparam logic REPLY_REPORT = 1'b0;
    localparam logic REPLY_BIN    = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pixel_value;
        logic [7:0] bin_index;
    } phs_in_t;

    typedef struct packed {
        logic        reply_kind;
        logic [7:0]  median_value;
        logic [15:0] mean_fixed;
        logic [7:0]  min_value;
        logic [7:0]  max_seen;
        logic [7:0]  mode_value;
        logic [23:0] mode_occurrences;
        logic [8:0]  mode_ties;
        logic [23:0] total_pixels;
        logic [23:0] bin_count;
        logic        is_empty;
        logic        out_of_range_seen;
    } phs_out_t;

endpackage

`default_nettype wire

/* hw/rtl/phs_bin_mem.sv */
// ----------------------------------------------------------------------------
// Histogram bin memory
// Synchronous bin store with registered read data and per-entry valid bits for instant clear.
// ----------------------------------------------------------------------------
`default_nettype none

module phs_bin_mem
    import phs_pkg::*;
#(
    parameter int DEPTH = BIN_COUNT_DEF,
    parameter int WIDTH = COUNT_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     clr,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem_ram [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] q_reg;
    logic             q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem_ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

`default_nettype wire

/* hw/rtl/phs_div.sv */
// ----------------------------------------------------------------------------
// Histogram mean divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module phs_div
    import phs_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = COUNT_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] quo,
    output logic               done
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        take     = (trial >= {1'b0, den_reg});
        rem_next = take ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(NW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], take};
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/pixel_histogram_statistics.sv */
// Add: a read-modify-write of one bin through the bin memory; input stalls until the write.
// Clear: bins are emptied at once by dropping their valid bits.
// Bin read: result registered in ST_RD, sent from ST_EMIT; input stalls until it is sent.
// Report: a sweep over bins 0 to top, a drain of the sweep pipeline and, unless empty,
// a divide for the mean, paced by the single bin memory read port.
// Reset: all bins empty, max_value 255, no clearing pass is needed.
// ----------------------------------------------------------------------------
// Pixel histogram statistics
// Grey pixel histogram with running min, max and count and a statistics report.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_histogram_statistics
    import phs_pkg::*;
#(
    parameter int BIN_COUNT  = BIN_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire phs_in_t  in_item,
    output logic          out_valid,
    input  wire logic     out_stall,
    output phs_out_t      out_item,
    input  wire logic     cfg_we,
    input  wire logic [7:0] cfg_data
);

    localparam int IDX_W  = $clog2(BIN_COUNT);
    localparam int SUM_W  = COUNT_BITS + IDX_W;
    localparam int PROD_W = COUNT_BITS + IDX_W;
    localparam int WSUM_W = COUNT_BITS + 2 * IDX_W;
    localparam int NUM_W  = WSUM_W + 8;
    localparam int TIE_W  = IDX_W + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ADD   = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_SWEEP = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [7:0]            max_value_reg;
    logic [7:0]            run_min_reg, run_min_next;
    logic [7:0]            run_max_reg, run_max_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  dropped_reg, dropped_next;
    logic                  out_valid_reg;
    logic                  s1_vld_reg;
    logic                  s2_vld_reg;

    logic [IDX_W-1:0]      add_idx_reg;
    logic                  idx_ok_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [WSUM_W-1:0]     wsum_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [IDX_W-1:0]      best_bin_reg;
    logic [TIE_W-1:0]      ties_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      median_reg;
    phs_out_t              res_reg;
    phs_out_t              out_item_reg;

    logic                  accept;
    logic [IDX_W-1:0]      top_bin;
    logic                  pix_ok;
    logic                  idx_ok;
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [COUNT_BITS-1:0] mem_rd_data;
    logic                  mem_wr_en;
    logic [COUNT_BITS-1:0] mem_wr_data;
    logic                  mem_clr;
    logic                  div_start;
    logic [NUM_W-1:0]      div_quo;
    logic                  div_done;
    logic [SUM_W-1:0]      sum_new;
    logic [15:0]           mean_w;
    logic                  empty;
    phs_out_t              rpt_item;
    phs_out_t              bin_item;
    logic [COUNT_BITS+23:0] best_ext;
    logic [COUNT_BITS+23:0] total_ext;
    logic [COUNT_BITS+23:0] rd_ext;
    logic [IDX_W+7:0]      median_ext;
    logic [IDX_W+7:0]      mode_ext;
    logic [TIE_W+8:0]      ties_ext;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        if ({1'b0, max_value_reg} > 9'(BIN_COUNT - 1))
        begin
            top_bin = IDX_W'(BIN_COUNT - 1);
        end
        else
        begin
            top_bin = max_value_reg[IDX_W-1:0];
        end
        pix_ok = ({1'b0, in_item.pixel_value} <= 9'(top_bin));
        idx_ok = ({1'b0, in_item.bin_index} < 9'(BIN_COUNT));
    end

    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = cnt_reg;
        if (state_reg == ST_SWEEP)
        begin
            mem_rd_en = 1'b1;
        end
        else if (accept && in_item.opcode == OP_ADD)
        begin
            mem_rd_en   = pix_ok;
            mem_rd_addr = in_item.pixel_value[IDX_W-1:0];
        end
        else if (accept && in_item.opcode == OP_READ)
        begin
            mem_rd_en   = idx_ok;
            mem_rd_addr = in_item.bin_index[IDX_W-1:0];
        end
        mem_wr_en   = (state_reg == ST_ADD);
        mem_wr_data = (mem_rd_data == CNT_MAX) ? mem_rd_data : mem_rd_data + 1'b1;
        mem_clr     = accept && (in_item.opcode == OP_CLEAR);
    end

    phs_bin_mem #(
        .DEPTH (BIN_COUNT),
        .WIDTH (COUNT_BITS)
    ) u_bin_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (add_idx_reg),
        .wr_data (mem_wr_data)
    );

    assign empty     = (total_reg == '0);
    assign div_start = (state_reg == ST_DRAIN) && !s1_vld_reg && !s2_vld_reg && !empty;

    phs_div #(
        .NW (NUM_W),
        .DW (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({wsum_reg, 8'b0}),
        .den   (total_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    always_comb
    begin
        mean_w     = (|div_quo[NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
        best_ext   = {24'b0, best_reg};
        total_ext  = {24'b0, total_reg};
        rd_ext     = {24'b0, mem_rd_data};
        median_ext = {8'b0, median_reg};
        mode_ext   = {8'b0, best_bin_reg};
        ties_ext   = {9'b0, ties_reg};

        rpt_item                   = '0;
        rpt_item.reply_kind        = REPLY_REPORT;
        rpt_item.median_value      = empty ? 8'd0 : median_ext[7:0];
        rpt_item.mean_fixed        = empty ? 16'd0 : mean_w;
        rpt_item.min_value         = empty ? max_value_reg : run_min_reg;
        rpt_item.max_seen          = empty ? 8'd0 : run_max_reg;
        rpt_item.mode_value        = mode_ext[7:0];
        rpt_item.mode_occurrences  = best_ext[23:0];
        rpt_item.mode_ties         = ties_ext[8:0];
        rpt_item.total_pixels      = total_ext[23:0];
        rpt_item.is_empty          = empty;
        rpt_item.out_of_range_seen = dropped_reg;

        bin_item            = '0;
        bin_item.reply_kind = REPLY_BIN;
        bin_item.bin_count  = idx_ok_reg ? rd_ext[23:0] : 24'd0;
    end

    always_comb
    begin
        state_next   = state_reg;
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_item.opcode)
                        OP_ADD:
                        begin
                            if (!pix_ok)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ADD;
                                if (total_reg != CNT_MAX)
                                begin
                                    total_next = total_reg + 1'b1;
                                end
                                if (in_item.pixel_value < run_min_reg)
                                begin
                                    run_min_next = in_item.pixel_value;
                                end
                                if (in_item.pixel_value > run_max_reg)
                                begin
                                    run_max_next = in_item.pixel_value;
                                end
                            end
                        end
                        OP_REPORT:
                        begin
                            state_next = ST_SWEEP;
                        end
                        OP_READ:
                        begin
                            state_next = ST_RD;
                        end
                        OP_CLEAR:
                        begin
                            run_min_next = max_value_reg;
                            run_max_next = '0;
                            total_next   = '0;
                            dropped_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == top_bin)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = empty ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_value_reg <= 8'hFF;
            run_min_reg   <= 8'hFF;
            run_max_reg   <= '0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
            s1_vld_reg  <= (state_reg == ST_SWEEP);
            s2_vld_reg  <= s1_vld_reg;
            if (cfg_we)
            begin
                max_value_reg <= cfg_data;
            end
            if (state_reg == ST_EMIT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sum_new = sum_reg + SUM_W'(mem_rd_data);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            add_idx_reg  <= in_item.pixel_value[IDX_W-1:0];
            idx_ok_reg   <= idx_ok;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            wsum_reg     <= '0;
            best_reg     <= '0;
            best_bin_reg <= '0;
            ties_reg     <= '0;
            found_reg    <= 1'b0;
            median_reg   <= top_bin;
        end
        if (state_reg == ST_SWEEP)
        begin
            cnt_reg    <= cnt_reg + 1'b1;
            s1_idx_reg <= cnt_reg;
        end
        if (s1_vld_reg)
        begin
            prod_reg <= PROD_W'(s1_idx_reg) * PROD_W'(mem_rd_data);
            sum_reg  <= sum_new;
            if (s1_idx_reg == '0 || mem_rd_data > best_reg)
            begin
                best_reg     <= mem_rd_data;
                best_bin_reg <= s1_idx_reg;
                ties_reg     <= TIE_W'(1);
            end
            else if (mem_rd_data == best_reg)
            begin
                ties_reg <= ties_reg + 1'b1;
            end
            if (!found_reg && sum_new >= SUM_W'(total_reg >> 1))
            begin
                median_reg <= s1_idx_reg;
                found_reg  <= 1'b1;
            end
        end
        if (s2_vld_reg)
        begin
            wsum_reg <= wsum_reg + WSUM_W'(prod_reg);
        end
        if (state_reg == ST_RD)
        begin
            res_reg <= bin_item;
        end
        else if ((state_reg == ST_DRAIN && empty) || (state_reg == ST_DIV && div_done))
        begin
            res_reg <= rpt_item;
        end
        if (state_reg == ST_EMIT && (!out_valid_reg || !out_stall))
        begin
            out_item_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`include "pixel_histogram_statistics_assert.svh"

    `PHS_ASSERT_NXT(a_add_goes_to_write, accept && in_item.opcode == OP_ADD && pix_ok,
        state_reg == ST_ADD, "legal add did not start a bin write")
    `PHS_ASSERT_IMP(a_min_le_max, total_reg != '0,
        run_min_reg <= run_max_reg, "running min above running max")
    `PHS_ASSERT_IMP(a_div_done_in_div, div_done,
        state_reg == ST_DIV, "divider finished outside the divide state")

endmodule

`default_nettype wire
